[rtl/semf_pkg.sv]
package semf_pkg;

    // Stream constants
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_LEN  = 2'd2;
    localparam int CFG_DATA_W = 64;
    localparam int MARKER_LEN_W = 5;

    // Input word
    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
    } semf_in_word_t;

    // Result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       marker_found;
        logic       last_of_run;
    } semf_out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic emit_load;
        logic commit;
    } semf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_scan;
        logic scan_hit;
        logic emit_empty;
        logic emit_last;
    } semf_status_t;

endpackage

[rtl/semf_ctrl.sv]
module semf_ctrl import semf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  semf_status_t status,
    output semf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    // Sequencing: take a word, scan match positions, emit the released run
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        slot_free    = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid && status.start_scan) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_hit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.emit_empty) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    cmd.emit_load = 1'b1;
                    m_valid_next  = 1'b1;
                    if (status.emit_last) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/semf_datapath.sv]
module semf_datapath import semf_pkg::*; #(
    parameter int MAX_MARKER_LEN = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  semf_in_word_t          s_data,
    output semf_out_word_t         m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  semf_cmd_t              cmd,
    output semf_status_t           status
);

    localparam int CNT_W = $clog2(MAX_MARKER_LEN + 1);
    localparam int SUM_W = CNT_W + 1;

    // Configuration
    logic [CFG_DATA_W-1:0]   marker_low_reg, marker_low_next;
    logic [CFG_DATA_W-1:0]   marker_high_reg, marker_high_next;
    logic [MARKER_LEN_W-1:0] marker_len_reg, marker_len_next;

    // Session state
    logic             skip_reg, skip_next;
    logic             fin_reg, fin_next;
    logic [CNT_W-1:0] held_reg, held_next;

    // Per-word working registers
    logic [7:0]       byte_reg, byte_next;
    logic [CNT_W-1:0] q_reg, q_next;
    logic             full_reg, full_next;
    logic [CNT_W-1:0] e_reg, e_next;
    semf_out_word_t   m_data_reg, m_data_next;

    logic [2*CFG_DATA_W-1:0] marker_all;
    logic [2*CFG_DATA_W-1:0] marker_shift;
    logic [2*CFG_DATA_W-1:0] emit_shift;
    logic [MARKER_LEN_W-1:0] len_clamp;
    logic [CNT_W-1:0]        len_eff;
    logic [CNT_W-1:0]        n_cnt;
    logic [CNT_W-1:0]        run_cnt;
    logic                    match;
    logic                    full_now;
    logic [7:0]              emit_byte;
    semf_out_word_t          emit_word;

    assign marker_all = {marker_high_reg, marker_low_reg};

    // Length in use, clamped to 1..MAX_MARKER_LEN
    always_comb begin
        if (marker_len_reg == '0) begin
            len_clamp = MARKER_LEN_W'(1);
        end else if (marker_len_reg > MARKER_LEN_W'(MAX_MARKER_LEN)) begin
            len_clamp = MARKER_LEN_W'(MAX_MARKER_LEN);
        end else begin
            len_clamp = marker_len_reg;
        end
    end
    assign len_eff = len_clamp[CNT_W-1:0];

    // Held bytes plus the new byte
    assign n_cnt = held_reg + CNT_W'(1);

    // Position comparator: does the marker prefix match the sequence at q?
    assign marker_shift = marker_all >> {q_reg, 3'b000};
    always_comb begin : pos_cmp
        logic [SUM_W-1:0] j;
        logic [7:0]       cand;
        match = 1'b1;
        for (int k = 0; k < MAX_MARKER_LEN; k++) begin
            j    = {1'b0, q_reg} + SUM_W'(k);
            cand = (j < {1'b0, held_reg}) ? marker_shift[8*k +: 8] : byte_reg;
            if ((SUM_W'(k) < {1'b0, len_eff}) && (j < {1'b0, n_cnt})) begin
                if (cand != marker_all[8*k +: 8]) begin
                    match = 1'b0;
                end
            end
        end
    end
    assign full_now = match && ((n_cnt - q_reg) >= len_eff);

    // Released run: q_reg bytes, then the marker result if one was found
    assign run_cnt    = q_reg + CNT_W'(full_reg);
    assign emit_shift = marker_all >> {e_reg, 3'b000};
    assign emit_byte  = (e_reg < held_reg) ? emit_shift[7:0] : byte_reg;

    always_comb begin
        emit_word.last_of_run = (e_reg == run_cnt - CNT_W'(1));
        if (e_reg < q_reg) begin
            emit_word.out_byte     = emit_byte;
            emit_word.byte_valid   = 1'b1;
            emit_word.marker_found = 1'b0;
        end else begin
            emit_word.out_byte     = '0;
            emit_word.byte_valid   = 1'b0;
            emit_word.marker_found = 1'b1;
        end
    end

    // Status to the controller
    assign status.start_scan = !s_data.command && !fin_reg && !skip_reg;
    assign status.scan_hit   = match || (q_reg == held_reg);
    assign status.emit_empty = (run_cnt == '0);
    assign status.emit_last  = emit_word.last_of_run;

    // Next-state logic
    always_comb begin
        marker_low_next  = marker_low_reg;
        marker_high_next = marker_high_reg;
        marker_len_next  = marker_len_reg;
        skip_next        = skip_reg;
        fin_next         = fin_reg;
        held_next        = held_reg;
        byte_next        = byte_reg;
        q_next           = q_reg;
        full_next        = full_reg;
        e_next           = e_reg;
        m_data_next      = m_data_reg;

        // Register writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MARKER_LOW:  marker_low_next  = cfg_wr_data;
                CFG_MARKER_HIGH: marker_high_next = cfg_wr_data;
                CFG_MARKER_LEN:  marker_len_next  = cfg_wr_data[MARKER_LEN_W-1:0];
                default: ;
            endcase
        end

        // Word intake: restart, echo skip, or start of a scan
        if (cmd.accept) begin
            byte_next = s_data.in_byte;
            q_next    = '0;
            full_next = 1'b0;
            e_next    = '0;
            if (s_data.command) begin
                skip_next = 1'b1;
                fin_next  = 1'b0;
                held_next = '0;
            end else if (!fin_reg && skip_reg && (s_data.in_byte == NEWLINE_BYTE)) begin
                skip_next = 1'b0;
            end
        end

        // One match position per cycle; stops at the first hit or after the last position
        if (cmd.scan_step) begin
            if (match) begin
                full_next = full_now;
            end else begin
                q_next = q_reg + CNT_W'(1);
            end
        end

        if (cmd.emit_load) begin
            e_next      = e_reg + CNT_W'(1);
            m_data_next = emit_word;
        end

        // End of word: keep the matched tail, or latch the marker hit
        if (cmd.commit) begin
            fin_next  = full_reg;
            held_next = full_reg ? '0 : (n_cnt - q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_low_reg  <= '0;
            marker_high_reg <= '0;
            marker_len_reg  <= MARKER_LEN_W'(1);
            skip_reg        <= 1'b1;
            fin_reg         <= 1'b0;
            held_reg        <= '0;
            q_reg           <= '0;
            full_reg        <= 1'b0;
            e_reg           <= '0;
        end else begin
            marker_low_reg  <= marker_low_next;
            marker_high_reg <= marker_high_next;
            marker_len_reg  <= marker_len_next;
            skip_reg        <= skip_next;
            fin_reg         <= fin_next;
            held_reg        <= held_next;
            q_reg           <= q_next;
            full_reg        <= full_next;
            e_reg           <= e_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
    end

    assign m_data = m_data_reg;

endmodule

[rtl/stream_end_marker_filter_core.sv]
// Stream end-marker filter. Takes one byte word per handshake; after a restart
// word it drops everything through the first newline (the echoed command line),
// then forwards bytes while holding back the longest tail that matches a prefix
// of the programmed end marker (up to MAX_MARKER_LEN bytes). A word that breaks
// a partial match releases the held bytes as a run; the full marker produces a
// final result with marker_found set, after which data words are swallowed
// until the next restart. last_of_run flags the last result of each input word.
// Restart, skipped and swallowed words are taken in the idle state. A forwarded
// data word is taken, then its match positions are scanned, S of them (1 to
// held bytes + 1, one per cycle in the shared position comparator), then its
// results are emitted, one per cycle through the single output register when
// the sink keeps up; only then is the next word taken. Program the marker
// registers only while the block is idle.
module stream_end_marker_filter_core import semf_pkg::*; #(
    parameter int MAX_MARKER_LEN = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  semf_in_word_t          s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output semf_out_word_t         m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    semf_cmd_t    cmd;
    semf_status_t status;

    semf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    semf_datapath #(
        .MAX_MARKER_LEN (MAX_MARKER_LEN)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

[rtl/semf_checker.sv]
module semf_checker import semf_pkg::*; (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input semf_out_word_t m_data
);

    // Output word is held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Marker result carries no byte and closes the run
    a_marker_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.marker_found |->
            m_data.last_of_run && !m_data.byte_valid && (m_data.out_byte == 8'h00))
        else $error("malformed marker result");

    // Every result is either a byte or the marker
    a_word_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_valid != m_data.marker_found))
        else $error("result is neither byte nor marker");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind stream_end_marker_filter_core semf_checker u_semf_checker (.*);
